FILE: rtl/core/tum_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tum_pkg: shared types and constants of the thresholded unsharp mask
// register layout, configuration bundle, sequencer states and fixed-point sizes
// ----------------------------------------------------------------------------
package tum_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PIX_W          = 16;

  // register field widths
  localparam int LW_W   = 12;
  localparam int FH_W   = 13;
  localparam int GEW_W  = 15;
  localparam int AMT_W  = 16;
  localparam int THR_W  = 20;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int GEW_MAX = 21845;

  // reset values
  localparam logic [LW_W-1:0]  LW_RESET  = 12'd640;
  localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
  localparam logic [GEW_W-1:0] GEW_RESET = 15'd16384;
  localparam logic [AMT_W-1:0] AMT_RESET = 16'd256;
  localparam logic [THR_W-1:0] THR_RESET = 20'd0;

  // fixed-point sizes
  localparam int MASK_W   = 26;
  localparam int COLSUM_W = 28;
  localparam int SUM9_W   = 30;

  // divide by nine as multiply by reciprocal, exact below 2^29
  localparam logic [29:0] DIV9_MUL   = 30'd954437177;
  localparam int          DIV9_SHIFT = 33;

  // last sequencer step of the read phase
  localparam logic [3:0] READ_LAST = 4'd10;
  localparam logic [3:0] READ_EMIT = 4'd9;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_GAUSS_EDGE   = 3'd2,
    REG_AMOUNT       = 3'd3,
    REG_THRESHOLD    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LW_W-1:0]  line_width;
    logic [FH_W-1:0]  frame_height;
    logic [GEW_W-1:0] gauss_edge_weight;
    logic [AMT_W-1:0] sharpen_amount;
    logic [THR_W-1:0] mask_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MASK,
    ST_SUM,
    ST_DIV,
    ST_SHARP,
    ST_OUT
  } state_t;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tum_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tum_regs: configuration registers
// apb write and read of the five setup registers
// ----------------------------------------------------------------------------
module tum_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tum_pkg::ADDR_W-1:0]  paddr,
  input  logic [tum_pkg::DATA_W-1:0]  pwdata,
  output logic [tum_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tum_pkg::cfg_t               cfg
);

  tum_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = tum_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width        <= tum_pkg::LW_RESET;
      cfg.frame_height      <= tum_pkg::FH_RESET;
      cfg.gauss_edge_weight <= tum_pkg::GEW_RESET;
      cfg.sharpen_amount    <= tum_pkg::AMT_RESET;
      cfg.mask_threshold    <= tum_pkg::THR_RESET;
    end else if (wr) begin
      unique case (idx)
        tum_pkg::REG_LINE_WIDTH:   cfg.line_width        <= pwdata[tum_pkg::LW_W-1:0];
        tum_pkg::REG_FRAME_HEIGHT: cfg.frame_height      <= pwdata[tum_pkg::FH_W-1:0];
        tum_pkg::REG_GAUSS_EDGE:   cfg.gauss_edge_weight <= pwdata[tum_pkg::GEW_W-1:0];
        tum_pkg::REG_AMOUNT:       cfg.sharpen_amount    <= pwdata[tum_pkg::AMT_W-1:0];
        tum_pkg::REG_THRESHOLD:    cfg.mask_threshold    <= pwdata[tum_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tum_pkg::REG_LINE_WIDTH:   prdata = 32'(cfg.line_width);
      tum_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg.frame_height);
      tum_pkg::REG_GAUSS_EDGE:   prdata = 32'(cfg.gauss_edge_weight);
      tum_pkg::REG_AMOUNT:       prdata = 32'(cfg.sharpen_amount);
      tum_pkg::REG_THRESHOLD:    prdata = 32'(cfg.mask_threshold);
      default:                   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/tum_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tum_core: line stores and sequenced datapath
// source and mask line memories, position tracking, blur, box mean, sharpen
// ----------------------------------------------------------------------------
module tum_core #(
  parameter int MAX_WIDTH  = tum_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tum_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tum_pkg::cfg_t              cfg,
  input  logic                       pix_valid,
  output logic                       pix_ready,
  input  logic                       op,
  input  logic [tum_pkg::PIX_W-1:0]  pixel_in,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [tum_pkg::PIX_W-1:0]  pixel_out,
  output logic                       end_of_line,
  output logic                       end_of_frame
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);
  localparam int SD  = 3 * MAX_WIDTH;
  localparam int SAW = $clog2(SD);
  localparam int MD  = 2 * MAX_WIDTH;
  localparam int MAW = $clog2(MD);
  localparam int PW  = tum_pkg::PIX_W;
  localparam int MW  = tum_pkg::MASK_W;
  localparam int CSW = tum_pkg::COLSUM_W;
  localparam int SW  = tum_pkg::SUM9_W;

  // clamped configuration
  logic [WW-1:0]  w;
  logic [RW-1:0]  h;
  logic [14:0]    we;
  logic [16:0]    wc;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hp2;

  // stream position
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [1:0]     slot;

  // item decode, combinational in idle
  logic           restart, inframe, ignore, do_mask, col_ge1, is_last;
  logic [CW-1:0]  cole, b, col_l, col_r;
  logic [RW-1:0]  rowe, a;
  logic [1:0]     slote, slot_a, slot_am1, slot_ap1;
  logic           accept;

  // latched item
  logic [RW-1:0]  it_a;
  logic [CW-1:0]  it_b, it_col_l, it_col_r, it_col_e;
  logic [1:0]     it_slot_ru, it_slot_a, it_slot_rd, it_slot_e;
  logic           it_e1, it_e2, it_upd, it_wr, it_a1, it_ah, it_eol, it_eof;

  tum_pkg::state_t state, state_next;

  // read sequencing
  logic [3:0]     cnt;
  logic [1:0]     ri, cj, p_i, p_j;
  logic           p_valid;
  logic [1:0]     rd_slot;
  logic [CW-1:0]  rd_col;

  // memories
  logic [PW-1:0]        src_mem [SD];
  logic [PW-1:0]        src_rdata;
  logic [SAW-1:0]       src_raddr, src_waddr;
  logic                 src_we;
  logic signed [MW-1:0] mask_mem [MD];
  logic signed [MW-1:0] mask_rdata;
  logic [MAW-1:0]       mask_raddr, mask_waddr;
  logic                 mask_we;

  // datapath
  logic [31:0]            hacc;
  logic [47:0]            blur;
  logic [32:0]            hprod;
  logic [48:0]            vprod;
  logic [16:0]            ccoef, rcoef;
  logic [PW-1:0]          center, epix;
  logic signed [MW-1:0]   cur, old, fresh, mask_val;
  logic [48:0]            blur_rnd;
  logic signed [CSW-1:0]  cs1, cs2, vs;
  logic signed [SW-1:0]   sum9, sum9_next;
  logic                   neg, hit;
  logic [28:0]            mag;
  logic [58:0]            qprod;
  logic [25:0]            q;
  logic signed [26:0]     s_val;
  logic signed [43:0]     sp;
  logic signed [44:0]     v;
  logic [28:0]            t;
  logic [PW-1:0]          sat;

  function automatic logic [SAW-1:0] src_addr(input logic [1:0] s, input logic [CW-1:0] c);
    logic [SAW-1:0] base;
    unique case (s)
      2'd0:    base = '0;
      2'd1:    base = SAW'(MAX_WIDTH);
      default: base = SAW'(2 * MAX_WIDTH);
    endcase
    return base + SAW'(c);
  endfunction

  function automatic logic [MAW-1:0] mask_addr(input logic par, input logic [CW-1:0] c);
    return par ? (MAW'(MAX_WIDTH) + MAW'(c)) : MAW'(c);
  endfunction

  // register clamping
  always_comb begin
    if (cfg.line_width < 12'd3)                 w = WW'(3);
    else if (int'(cfg.line_width) > MAX_WIDTH)  w = WW'(MAX_WIDTH);
    else                                        w = WW'(cfg.line_width);
    if (cfg.frame_height < 13'd3)                h = RW'(3);
    else if (int'(cfg.frame_height) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
    else                                         h = RW'(cfg.frame_height);
    we  = (int'(cfg.gauss_edge_weight) > tum_pkg::GEW_MAX) ? 15'(tum_pkg::GEW_MAX)
                                                           : cfg.gauss_edge_weight;
    wc  = 17'h10000 - {1'b0, we, 1'b0};
    wm1 = CW'(w - WW'(1));
    hp2 = h + RW'(2);
  end

  // position decode of the offered item
  always_comb begin
    restart  = (WW'(col) >= w) || (row > hp2) || ((row == hp2) && (col > CW'(1)));
    rowe     = restart ? '0 : row;
    cole     = restart ? '0 : col;
    slote    = restart ? 2'd0 : slot;
    inframe  = rowe < h;
    ignore   = inframe && op;
    col_ge1  = cole != '0;
    do_mask  = (rowe >= RW'(2)) || ((rowe == RW'(1)) && col_ge1);
    is_last  = (rowe == hp2) && (cole == CW'(1));
    a        = col_ge1 ? rowe - RW'(1) : rowe - RW'(2);
    b        = col_ge1 ? cole - CW'(1) : wm1;
    slot_a   = col_ge1 ? tum_pkg::slot_dec(slote) : tum_pkg::slot_inc(slote);
    slot_am1 = tum_pkg::slot_dec(slot_a);
    slot_ap1 = tum_pkg::slot_inc(slot_a);
    col_l    = (b == '0) ? CW'(1) : b - CW'(1);
    col_r    = (b == wm1) ? b - CW'(1) : b + CW'(1);
  end

  assign accept    = (state == tum_pkg::ST_IDLE) && pix_valid;
  assign src_we    = accept && inframe && !op;
  assign src_waddr = src_addr(slote, cole);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= tum_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pix_ready  = 1'b0;
    unique case (state)
      tum_pkg::ST_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid && !ignore && do_mask) state_next = tum_pkg::ST_READ;
      end
      tum_pkg::ST_READ: begin
        if (cnt == tum_pkg::READ_LAST) state_next = tum_pkg::ST_MASK;
      end
      tum_pkg::ST_MASK:  state_next = tum_pkg::ST_SUM;
      tum_pkg::ST_SUM: begin
        state_next = (it_e1 || it_e2) ? tum_pkg::ST_DIV : tum_pkg::ST_IDLE;
      end
      tum_pkg::ST_DIV:   state_next = tum_pkg::ST_SHARP;
      tum_pkg::ST_SHARP: state_next = tum_pkg::ST_OUT;
      tum_pkg::ST_OUT: begin
        if (!res_valid || res_ready) state_next = tum_pkg::ST_IDLE;
      end
      default: state_next = tum_pkg::ST_IDLE;
    endcase
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= 2'd0;
    end else if (accept) begin
      if (ignore) begin
        col  <= cole;
        row  <= rowe;
        slot <= slote;
      end else if (is_last) begin
        col  <= '0;
        row  <= '0;
        slot <= 2'd0;
      end else if (WW'(cole) + WW'(1) >= w) begin
        col  <= '0;
        row  <= rowe + RW'(1);
        slot <= tum_pkg::slot_inc(slote);
      end else begin
        col  <= cole + CW'(1);
        row  <= rowe;
        slot <= slote;
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      it_a       <= a;
      it_b       <= b;
      it_col_l   <= col_l;
      it_col_r   <= col_r;
      it_slot_a  <= slot_a;
      it_slot_ru <= (a == '0) ? slot_ap1 : slot_am1;
      it_slot_rd <= (a == h - RW'(1)) ? slot_am1 : slot_ap1;
      it_e1      <= (b == '0) && (a >= RW'(2));
      it_e2      <= (a >= RW'(1)) && (a <= h) && (b != '0);
      it_upd     <= (a >= RW'(1)) && (a <= h);
      it_wr      <= a < h;
      it_a1      <= a == RW'(1);
      it_ah      <= a == h;
      // left-over row sits one slot above row a, as a-2 does
      it_slot_e  <= ((b == '0) && (a >= RW'(2))) ? slot_ap1 : slot_am1;
      it_col_e   <= (b == '0) ? wm1 : b - CW'(1);
      it_eol     <= b == '0;
      it_eof     <= (b == '0) && (a == h + RW'(1));
    end
  end

  // read sequencing
  always_comb begin
    unique case (ri)
      2'd0:    rd_slot = it_slot_ru;
      2'd1:    rd_slot = it_slot_a;
      2'd2:    rd_slot = it_slot_rd;
      default: rd_slot = it_slot_e;
    endcase
    if (ri == 2'd3)      rd_col = it_col_e;
    else if (cj == 2'd0) rd_col = it_col_l;
    else if (cj == 2'd1) rd_col = it_b;
    else                 rd_col = it_col_r;
  end

  assign src_raddr  = src_addr(rd_slot, rd_col);
  assign mask_raddr = (cnt == 4'd0) ? mask_addr(~it_a[0], it_b) : mask_addr(it_a[0], it_b);
  assign mask_we    = (state == tum_pkg::ST_SUM) && it_wr;
  assign mask_waddr = mask_addr(it_a[0], it_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == tum_pkg::ST_READ) && (cnt <= tum_pkg::READ_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
      ri  <= 2'd0;
      cj  <= 2'd0;
    end else if (state == tum_pkg::ST_READ) begin
      cnt <= cnt + 4'd1;
      if (cj == 2'd2) begin
        cj <= 2'd0;
        ri <= ri + 2'd1;
      end else begin
        cj <= cj + 2'd1;
      end
    end
    p_i <= ri;
    p_j <= cj;
  end

  // memories
  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_waddr] <= pixel_in;
    src_rdata <= src_mem[src_raddr];
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_waddr] <= fresh;
    mask_rdata <= mask_mem[mask_raddr];
  end

  // separable blur, one tap per cycle
  assign ccoef = (p_j == 2'd1) ? wc : {2'b00, we};
  assign rcoef = (p_i == 2'd2) ? wc : {2'b00, we};
  assign hprod = ccoef * src_rdata;
  assign vprod = rcoef * hacc;

  always_ff @(posedge clk) begin
    if (accept) begin
      blur <= '0;
    end else if (p_valid) begin
      if (p_j == 2'd0 && p_i != 2'd0) blur <= blur + vprod[47:0];
      if (p_i != 2'd3) hacc <= ((p_j == 2'd0) ? 32'd0 : hacc) + hprod[31:0];
      if (p_i == 2'd1 && p_j == 2'd1) center <= src_rdata;
      if (p_i == 2'd3) epix <= src_rdata;
    end
    if (state == tum_pkg::ST_READ && cnt == 4'd1) cur <= mask_rdata;
    if (state == tum_pkg::ST_READ && cnt == 4'd2) old <= mask_rdata;
  end

  // mask, box mean, sharpen
  assign blur_rnd = {1'b0, blur} + 49'h800000;
  assign mask_val = $signed({2'b00, center, 8'h00}) - $signed({1'b0, blur_rnd[48:24]});

  always_comb begin
    if (it_a1)      vs = (CSW'(fresh) <<< 1) + CSW'(cur);
    else if (it_ah) vs = (CSW'(old) <<< 1) + CSW'(cur);
    else            vs = CSW'(old) + CSW'(cur) + CSW'(fresh);
    if (it_e1)                     sum9_next = (SW'(cs1) <<< 1) + SW'(cs2);
    else if (it_b == CW'(1))       sum9_next = (SW'(vs) <<< 1) + SW'(cs2);
    else                           sum9_next = SW'(cs1) + SW'(cs2) + SW'(vs);
  end

  assign mag   = sum9[SW-1] ? 29'(-sum9) : 29'(sum9);
  assign q     = qprod[58:tum_pkg::DIV9_SHIFT];
  assign s_val = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign v     = $signed({13'd0, epix, 16'd0}) + 45'(sp);
  assign t     = v[44:16] + 29'(v[15]);
  assign sat   = v[44] ? '0 : ((t > 29'hFFFF) ? 16'hFFFF : t[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cs1 <= '0;
      cs2 <= '0;
    end else if (state == tum_pkg::ST_SUM && it_upd) begin
      cs1 <= cs2;
      cs2 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tum_pkg::ST_MASK) fresh <= mask_val;
    if (state == tum_pkg::ST_SUM)  sum9  <= sum9_next;
    if (state == tum_pkg::ST_DIV) begin
      neg   <= sum9[SW-1];
      qprod <= (mag + 29'd4) * tum_pkg::DIV9_MUL;
    end
    if (state == tum_pkg::ST_SHARP) begin
      hit <= q >= 26'({cfg.mask_threshold, 4'h0});
      sp  <= $signed({1'b0, cfg.sharpen_amount}) * s_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == tum_pkg::ST_OUT && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tum_pkg::ST_OUT && (!res_valid || res_ready)) begin
      pixel_out    <= hit ? sat : epix;
      end_of_line  <= it_eol;
      end_of_frame <= it_eof;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/thresholded_unsharp_mask_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thresholded_unsharp_mask_top: thresholded unsharp mask on a pixel stream
// apb setup registers plus the line-store sharpening core
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pix beat and sharpened pixels leave on
// the res beat, trailing the input by two lines plus two pixels; after the
// last pixel of a frame, 2*line_width+2 flush beats (op high) push the tail
// out, and a flush inside the frame is dropped. A pixel that triggers work
// runs the read phase and the mask and box-sum steps, then, if it yields a
// result, the divide, sharpen and output steps; a pixel early in the frame
// is only stored. The read phase comes from the single read port of the
// source line store, which supplies the nine blur taps and the output pixel
// one per cycle. The result register lets a new pixel in while the last
// result waits. Configuration goes through the apb port at byte offset
// 4*index and must only change while the block is idle.
module thresholded_unsharp_mask_top #(
  parameter int MAX_WIDTH  = tum_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tum_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // setup port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tum_pkg::ADDR_W-1:0]  paddr,
  input  logic [tum_pkg::DATA_W-1:0]  pwdata,
  output logic [tum_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // pixel input
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  logic                        op,
  input  logic [tum_pkg::PIX_W-1:0]   pixel_in,
  // result output
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [tum_pkg::PIX_W-1:0]   pixel_out,
  output logic                        end_of_line,
  output logic                        end_of_frame
);

  // raw register values, clamped inside the core
  tum_pkg::cfg_t cfg;

  tum_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // line stores, sequencer and arithmetic
  tum_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .op           (op),
    .pixel_in     (pixel_in),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .pixel_out    (pixel_out),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

endmodule
`default_nettype wire

FILE: rtl/core/tum_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tum_checker: port-level checks of the sharpening block
// result beat holding, flag consistency, reset behavior
// ----------------------------------------------------------------------------
module tum_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pready,
  input logic                       pix_valid,
  input logic                       pix_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [tum_pkg::PIX_W-1:0]  pixel_out,
  input logic                       end_of_line,
  input logic                       end_of_frame
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pixel_out) && $stable(end_of_frame))
    else $error("stalled result changed");

  // frame end only on a line end
  a_eof_eol: assert property (@(posedge clk) disable iff (rst)
    res_valid && end_of_frame |-> end_of_line)
    else $error("end_of_frame without end_of_line");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid && pix_ready)
    else $error("block not idle after reset");

  // the setup port stays ready while pixel beats are taken
  a_pix_gap: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |-> pready)
    else $error("setup port not ready");

endmodule

bind thresholded_unsharp_mask_top tum_checker u_tum_checker (.*);
`default_nettype wire
